@@ rtl/core/header_parameter_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// Header parameter tokenizer assertion macros
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HEADER_PARAMETER_TOKENIZER_ASSERT_SVH
`define HEADER_PARAMETER_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define HPT_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, codes and helpers of the header parameter tokenizer.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned SpaceRunMax = 255;
  localparam int unsigned RunCap      = (SpaceRunMax > 255) ? 255 : SpaceRunMax;

  localparam int unsigned CharW = 16;
  localparam int unsigned RunW  = 8;
  localparam int unsigned KindW = 3;

  localparam logic [CharW-1:0] ChSpace     = 16'd32;
  localparam logic [CharW-1:0] ChQuote     = 16'd34;
  localparam logic [CharW-1:0] ChEquals    = 16'd61;
  localparam logic [CharW-1:0] ChBackslash = 16'd92;
  localparam logic [CharW-1:0] ChSemi      = 16'd59;

  localparam int unsigned AddrW = 4;
  localparam logic [1:0] CfgSeparator = 2'd0;
  localparam logic [1:0] CfgEscOff    = 2'd1;
  localparam logic [1:0] CfgLeadMode  = 2'd2;

  localparam logic [CharW-1:0] SeparatorRst = 16'd59;

  typedef enum logic [KindW-1:0] {
    KIND_LEAD_CHAR  = 3'd0,
    KIND_NAME_CHAR  = 3'd1,
    KIND_VALUE_CHAR = 3'd2,
    KIND_LEAD_END   = 3'd3,
    KIND_KEEP       = 3'd4,
    KIND_DROP       = 3'd5,
    KIND_INPUT_END  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [RunW-1:0]  space_run;
    logic [CharW-1:0] char_out;
    logic             run_saturated;
    logic             end_of_string;
  } res_t;

  function automatic logic is_ws(logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= 16'd9) && (c <= 16'd13));
  endfunction

endpackage

@@ rtl/core/hpt_if.sv @@
// ----------------------------------------------------------------------------
// hpt_if
// Valid/ready channels for characters in and tagged results out.
// ----------------------------------------------------------------------------
interface hpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [hpt_pkg::CharW-1:0] char_in;
  logic                      last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface hpt_out_if;
  logic                      valid;
  logic                      ready;
  logic [hpt_pkg::KindW-1:0] kind;
  logic [hpt_pkg::RunW-1:0]  space_run;
  logic [hpt_pkg::CharW-1:0] char_out;
  logic                      run_saturated;
  logic                      end_of_string;

  modport source (output valid, output kind, output space_run, output char_out,
                  output run_saturated, output end_of_string, input ready);
  modport sink   (input valid, input kind, input space_run, input char_out,
                  input run_saturated, input end_of_string, output ready);
endinterface

@@ rtl/core/header_parameter_tokenizer.sv @@
// An accepted item waits in the input register; its results load into the result pair.
// Throughput: one item per cycle while the pair has room; an item with two results
// (the last character of a string) holds the output pair register until both are taken.
// The rate is set by the single input register feeding the two-slot result pair.
// Reset (rst_ni low, async): registers to defaults, string start pending, queues empty.
// ----------------------------------------------------------------------------
// header_parameter_tokenizer
// Splits a header value into lead, name and value characters plus markers.
// ----------------------------------------------------------------------------
`include "header_parameter_tokenizer_assert.svh"

module header_parameter_tokenizer #(
  parameter int unsigned SpaceRunMax = hpt_pkg::SpaceRunMax
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpt_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  hpt_in_if.sink                        in_i,
  hpt_out_if.source                     out_o
);

  localparam int unsigned RunCap = (SpaceRunMax > 255) ? 255 : SpaceRunMax;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_NAME   = 3'd1,
    PH_VSKIP  = 3'd2,
    PH_VALUE  = 3'd3,
    PH_QUOTED = 3'd4,
    PH_VESC   = 3'd5,
    PH_QESC   = 3'd6
  } phase_e;

  // config
  logic [hpt_pkg::CharW-1:0] sep_q;
  logic                      esc_off_q;
  logic                      lead_mode_q;
  logic                      cfg_wr;

  // input register
  logic                      iv_q;
  logic [hpt_pkg::CharW-1:0] ic_q;
  logic                      il_q;

  // parser state
  phase_e                    phase_q, phase_d;
  logic                      start_q, start_d;
  logic                      fs_q, fs_d;
  logic                      nn_q, nn_d;
  logic [hpt_pkg::RunW-1:0]  hs_q, hs_d;
  logic                      ho_q, ho_d;

  // result pair
  logic                      pv0_q, pv1_q;
  hpt_pkg::res_t             pr0_q, pr1_q;

  hpt_pkg::res_t             r0, r1;
  logic                      r0v, r1v;
  logic                      adv, pair_free, load, take;

  phase_e                    ph;
  logic                      txt;
  logic                      txt_nm;
  hpt_pkg::kind_e            txt_kind;
  logic                      started;

  logic                      out_marker;
  logic                      out_blank;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      hpt_pkg::CfgSeparator: prdata = {16'd0, sep_q};
      hpt_pkg::CfgEscOff:    prdata = {31'd0, esc_off_q};
      hpt_pkg::CfgLeadMode:  prdata = {31'd0, lead_mode_q};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    ph       = start_q ? (lead_mode_q ? PH_LEAD : PH_NAME) : phase_q;
    phase_d  = ph;
    start_d  = 1'b0;
    fs_d     = fs_q;
    nn_d     = nn_q;
    hs_d     = hs_q;
    ho_d     = ho_q;
    r0v      = 1'b0;
    r1v      = 1'b0;
    r0       = '0;
    r1       = '0;
    txt      = 1'b0;
    txt_nm   = 1'b0;
    txt_kind = hpt_pkg::KIND_VALUE_CHAR;
    started  = 1'b0;

    unique case (ph)
      PH_LEAD: begin
        if (!(!fs_q && hpt_pkg::is_ws(ic_q))) begin
          if (ic_q == hpt_pkg::ChSemi) begin
            r0v       = 1'b1;
            r0.kind   = hpt_pkg::KIND_LEAD_END;
            phase_d   = PH_NAME;
            fs_d      = 1'b0;
            nn_d      = 1'b0;
            hs_d      = '0;
            ho_d      = 1'b0;
          end else begin
            txt      = 1'b1;
            txt_kind = hpt_pkg::KIND_LEAD_CHAR;
          end
        end
      end
      PH_NAME: begin
        if (!nn_q && hpt_pkg::is_ws(ic_q)) begin
          fs_d = 1'b1;
        end else if (ic_q == sep_q) begin
          r0v     = 1'b1;
          r0.kind = nn_q ? hpt_pkg::KIND_KEEP : hpt_pkg::KIND_DROP;
          phase_d = PH_NAME;
          fs_d    = 1'b0;
          nn_d    = 1'b0;
          hs_d    = '0;
          ho_d    = 1'b0;
        end else if (ic_q == hpt_pkg::ChEquals) begin
          hs_d    = '0;
          ho_d    = 1'b0;
          fs_d    = 1'b0;
          phase_d = PH_VSKIP;
        end else begin
          fs_d     = 1'b1;
          txt      = 1'b1;
          txt_nm   = 1'b1;
          txt_kind = hpt_pkg::KIND_NAME_CHAR;
        end
      end
      PH_VSKIP, PH_VALUE: begin
        if (!(ph == PH_VSKIP && hpt_pkg::is_ws(ic_q))) begin
          phase_d = PH_VALUE;
          if (ic_q == sep_q) begin
            r0v     = 1'b1;
            r0.kind = nn_q ? hpt_pkg::KIND_KEEP : hpt_pkg::KIND_DROP;
            phase_d = PH_NAME;
            fs_d    = 1'b0;
            nn_d    = 1'b0;
            hs_d    = '0;
            ho_d    = 1'b0;
          end else if (ic_q == hpt_pkg::ChQuote) begin
            phase_d = PH_QUOTED;
          end else if (ic_q == hpt_pkg::ChBackslash && !esc_off_q) begin
            phase_d = PH_VESC;
          end else begin
            txt = 1'b1;
          end
        end
      end
      PH_QUOTED: begin
        if (ic_q == hpt_pkg::ChQuote) begin
          phase_d = PH_VALUE;
        end else if (ic_q == hpt_pkg::ChBackslash && !esc_off_q) begin
          phase_d = PH_QESC;
        end else begin
          txt = 1'b1;
        end
      end
      PH_VESC: begin
        txt     = 1'b1;
        phase_d = PH_VALUE;
      end
      PH_QESC: begin
        txt     = 1'b1;
        phase_d = PH_QUOTED;
      end
      default: begin
        phase_d = PH_NAME;
        fs_d    = 1'b0;
        nn_d    = 1'b0;
        hs_d    = '0;
        ho_d    = 1'b0;
      end
    endcase

    if (txt) begin
      if (ic_q == hpt_pkg::ChSpace) begin
        started = txt_nm ? nn_d : fs_d;
        if (started) begin
          if (hs_d >= hpt_pkg::RunW'(RunCap)) begin
            ho_d = 1'b1;
          end else begin
            hs_d = hs_d + hpt_pkg::RunW'(1);
          end
        end
      end else begin
        r0v              = 1'b1;
        r0.kind          = txt_kind;
        r0.space_run     = hs_d;
        r0.char_out      = ic_q;
        r0.run_saturated = ho_d;
        hs_d             = '0;
        ho_d             = 1'b0;
        if (txt_nm) begin
          nn_d = 1'b1;
        end else begin
          fs_d = 1'b1;
        end
      end
    end

    if (il_q) begin
      r1v = 1'b1;
      r1.end_of_string = 1'b1;
      if (phase_d == PH_LEAD) begin
        r1.kind = hpt_pkg::KIND_LEAD_END;
      end else if (phase_d == PH_NAME && !fs_d) begin
        r1.kind = hpt_pkg::KIND_INPUT_END;
      end else begin
        r1.kind = nn_d ? hpt_pkg::KIND_KEEP : hpt_pkg::KIND_DROP;
      end
      start_d = 1'b1;
      phase_d = PH_NAME;
      fs_d    = 1'b0;
      nn_d    = 1'b0;
      hs_d    = '0;
      ho_d    = 1'b0;
    end
  end

  assign take       = out_o.valid & out_o.ready;
  assign pair_free  = (!pv0_q && !pv1_q) || (take && (pv0_q ^ pv1_q));
  assign adv        = iv_q && (pair_free || (!r0v && !r1v));
  assign load       = adv && (r0v || r1v);
  assign in_i.ready = !iv_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= hpt_pkg::SeparatorRst;
      esc_off_q   <= 1'b0;
      lead_mode_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hpt_pkg::CfgSeparator: sep_q       <= pwdata[hpt_pkg::CharW-1:0];
        hpt_pkg::CfgEscOff:    esc_off_q   <= pwdata[0];
        hpt_pkg::CfgLeadMode:  lead_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      phase_q <= PH_NAME;
      start_q <= 1'b1;
      fs_q    <= 1'b0;
      nn_q    <= 1'b0;
      hs_q    <= '0;
      ho_q    <= 1'b0;
      pv0_q   <= 1'b0;
      pv1_q   <= 1'b0;
    end else begin
      if (in_i.ready) begin
        iv_q <= in_i.valid;
      end
      if (adv) begin
        phase_q <= phase_d;
        start_q <= start_d;
        fs_q    <= fs_d;
        nn_q    <= nn_d;
        hs_q    <= hs_d;
        ho_q    <= ho_d;
      end
      if (load) begin
        pv0_q <= r0v;
        pv1_q <= r1v;
      end else if (take) begin
        if (pv0_q) begin
          pv0_q <= 1'b0;
        end else begin
          pv1_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ic_q <= in_i.char_in;
      il_q <= in_i.last_char;
    end
    if (load) begin
      pr0_q <= r0;
      pr1_q <= r1;
    end
  end

  assign out_o.valid         = pv0_q | pv1_q;
  assign out_o.kind          = pv0_q ? pr0_q.kind          : pr1_q.kind;
  assign out_o.space_run     = pv0_q ? pr0_q.space_run     : pr1_q.space_run;
  assign out_o.char_out      = pv0_q ? pr0_q.char_out      : pr1_q.char_out;
  assign out_o.run_saturated = pv0_q ? pr0_q.run_saturated : pr1_q.run_saturated;
  assign out_o.end_of_string = pv0_q ? pr0_q.end_of_string : pr1_q.end_of_string;

  assign out_marker = out_o.valid && (out_o.kind >= hpt_pkg::KIND_LEAD_END);
  assign out_blank  = (out_o.char_out == '0) && (out_o.space_run == '0) &&
                      !out_o.run_saturated;

  `HPT_ASSERT(a_slot1_closes, pv1_q, pr1_q.end_of_string, "second slot not a closing marker")
  `HPT_ASSERT(a_slot0_no_eos, pv0_q, !pr0_q.end_of_string, "end of string on first slot")
  `HPT_ASSERT(a_marker_zero, out_marker, out_blank, "marker carries payload")
  `HPT_ASSERT_NEXT(a_item_held, iv_q && !adv, iv_q && $stable({ic_q, il_q}), "held item changed")

endmodule

@@ bench/hpt_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_stream_checker
// Watches the character and result channels and the register port. It keeps
// its own copy of the tokenizer state, works out the results each accepted
// character should produce, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module hpt_stream_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [hpt_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  input  logic                      pready_i,
  hpt_in_if                         chars_i,
  hpt_out_if                        results_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o
);

  typedef enum logic [2:0] {
    ST_LEAD, ST_NAME, ST_VSKIP, ST_VALUE, ST_QUOTED, ST_VESC, ST_QESC
  } scan_e;

  logic [hpt_pkg::CharW-1:0] sep_char;
  logic                      esc_off;
  logic                      lead_mode;

  scan_e                     scan;
  logic                      field_started;
  logic                      name_nonempty;
  logic [hpt_pkg::RunW-1:0]  held_spaces;
  logic                      held_ovf;
  logic                      string_start;

  hpt_pkg::res_t             step_res [2];
  int                        step_cnt;
  hpt_pkg::res_t             expected_q [$];

  function automatic logic blank(input logic [hpt_pkg::CharW-1:0] c);
    return (c == hpt_pkg::ChSpace) || ((c >= 16'd9) && (c <= 16'd13));
  endfunction

  task automatic emit(input hpt_pkg::kind_e k, input logic [hpt_pkg::RunW-1:0] run,
                      input logic [hpt_pkg::CharW-1:0] ch, input logic sat);
    if (step_cnt < 2) begin
      step_res[step_cnt].kind          = k;
      step_res[step_cnt].space_run     = run;
      step_res[step_cnt].char_out      = ch;
      step_res[step_cnt].run_saturated = sat;
      step_res[step_cnt].end_of_string = 1'b0;
      step_cnt++;
    end
  endtask

  task automatic drop_held();
    held_spaces = '0;
    held_ovf    = 1'b0;
  endtask

  task automatic clear_param();
    scan          = ST_NAME;
    field_started = 1'b0;
    name_nonempty = 1'b0;
    drop_held();
  endtask

  task automatic close_param();
    emit(name_nonempty ? hpt_pkg::KIND_KEEP : hpt_pkg::KIND_DROP, '0, '0, 1'b0);
    clear_param();
  endtask

  task automatic new_string();
    clear_param();
    scan         = lead_mode ? ST_LEAD : ST_NAME;
    string_start = 1'b1;
  endtask

  // spaces are only counted once the field has a visible character
  task automatic put_text(input hpt_pkg::kind_e k, input logic [hpt_pkg::CharW-1:0] c);
    logic started;
    started = (k == hpt_pkg::KIND_NAME_CHAR) ? name_nonempty : field_started;
    if (c == hpt_pkg::ChSpace) begin
      if (started) begin
        if (held_spaces >= hpt_pkg::RunCap) held_ovf = 1'b1;
        else held_spaces = held_spaces + 8'd1;
      end
    end else begin
      emit(k, held_spaces, c, held_ovf);
      drop_held();
      if (k == hpt_pkg::KIND_NAME_CHAR) name_nonempty = 1'b1;
      else field_started = 1'b1;
    end
  endtask

  task automatic tokenize(input logic [hpt_pkg::CharW-1:0] c, input logic fin);
    step_cnt = 0;
    if (string_start) begin
      scan         = lead_mode ? ST_LEAD : ST_NAME;
      string_start = 1'b0;
    end
    case (scan)
      ST_LEAD: begin
        if (field_started || !blank(c)) begin
          if (c == hpt_pkg::ChSemi) begin
            emit(hpt_pkg::KIND_LEAD_END, '0, '0, 1'b0);
            clear_param();
          end else begin
            put_text(hpt_pkg::KIND_LEAD_CHAR, c);
          end
        end
      end
      ST_NAME: begin
        if (!name_nonempty && blank(c)) begin
          field_started = 1'b1;
        end else if (c == sep_char) begin
          close_param();
        end else if (c == hpt_pkg::ChEquals) begin
          drop_held();
          field_started = 1'b0;
          scan          = ST_VSKIP;
        end else begin
          field_started = 1'b1;
          put_text(hpt_pkg::KIND_NAME_CHAR, c);
        end
      end
      ST_VSKIP, ST_VALUE: begin
        if (!(scan == ST_VSKIP && blank(c))) begin
          scan = ST_VALUE;
          if (c == sep_char) close_param();
          else if (c == hpt_pkg::ChQuote) scan = ST_QUOTED;
          else if (c == hpt_pkg::ChBackslash && !esc_off) scan = ST_VESC;
          else put_text(hpt_pkg::KIND_VALUE_CHAR, c);
        end
      end
      ST_QUOTED: begin
        if (c == hpt_pkg::ChQuote) scan = ST_VALUE;
        else if (c == hpt_pkg::ChBackslash && !esc_off) scan = ST_QESC;
        else put_text(hpt_pkg::KIND_VALUE_CHAR, c);
      end
      ST_VESC: begin
        put_text(hpt_pkg::KIND_VALUE_CHAR, c);
        scan = ST_VALUE;
      end
      ST_QESC: begin
        put_text(hpt_pkg::KIND_VALUE_CHAR, c);
        scan = ST_QUOTED;
      end
      default: clear_param();
    endcase
    if (fin) begin
      if (scan == ST_LEAD) emit(hpt_pkg::KIND_LEAD_END, '0, '0, 1'b0);
      else if (scan == ST_NAME && !field_started)
        emit(hpt_pkg::KIND_INPUT_END, '0, '0, 1'b0);
      else emit(name_nonempty ? hpt_pkg::KIND_KEEP : hpt_pkg::KIND_DROP, '0, '0, 1'b0);
      step_res[step_cnt-1].end_of_string = 1'b1;
      new_string();
    end
    for (int i = 0; i < step_cnt; i++) expected_q.insert(expected_q.size(), step_res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hpt_pkg::res_t got;
    hpt_pkg::res_t want;
    if (!rst_ni) begin
      sep_char     = hpt_pkg::SeparatorRst;
      esc_off      = 1'b0;
      lead_mode    = 1'b1;
      new_string();
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[hpt_pkg::AddrW-1:2])
          hpt_pkg::CfgSeparator: sep_char  = pwdata_i[hpt_pkg::CharW-1:0];
          hpt_pkg::CfgEscOff:    esc_off   = pwdata_i[0];
          hpt_pkg::CfgLeadMode:  lead_mode = pwdata_i[0];
          default: ;
        endcase
      end
      if (chars_i.valid && chars_i.ready) tokenize(chars_i.char_in, chars_i.last_char);
      if (results_i.valid && results_i.ready) begin
        got.kind          = results_i.kind;
        got.space_run     = results_i.space_run;
        got.char_out      = results_i.char_out;
        got.run_saturated = results_i.run_saturated;
        got.end_of_string = results_i.end_of_string;
        checked_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected item kind %0d run %0d char %h sat %b eos %b", $time,
                   got.kind, got.space_run, got.char_out, got.run_saturated,
                   got.end_of_string);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: mismatch expected kind %0d run %0d char %h sat %b eos %b",
                     $time, want.kind, want.space_run, want.char_out,
                     want.run_saturated, want.end_of_string);
            $display("%0t:            actual kind %0d run %0d char %h sat %b eos %b",
                     $time, got.kind, got.space_run, got.char_out,
                     got.run_saturated, got.end_of_string);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ bench/header_parameter_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_parameter_tokenizer_tb
// Feeds header strings into the tokenizer under a series of register settings:
// a short directed string first, then random well-formed headers mixed with
// noise. Both channels idle at random, the output is held off for one long
// stretch, and the checker compares every result against its own model.
// ----------------------------------------------------------------------------
module header_parameter_tokenizer_tb;

  localparam int unsigned HalfPeriod  = 2;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseChars  = 210;
  localparam int unsigned SettleDelay = 8;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [hpt_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  hpt_in_if  chars_ch ();
  hpt_out_if results_ch ();

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      checked;
  int unsigned      chars_sent;
  int unsigned      strings_sent;
  int unsigned      phase_chars;
  int unsigned      settings_run;
  int unsigned      cycle_count;

  logic [hpt_pkg::CharW-1:0] header_q [$];
  logic [hpt_pkg::CharW-1:0] cur_sep;
  logic                      cur_lead;
  logic                      idle_on;
  logic                      hold_req;

  always #HalfPeriod clk_i = ~clk_i;

  header_parameter_tokenizer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (chars_ch),
    .out_o   (results_ch)
  );

  hpt_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .chars_i      (chars_ch),
    .results_i    (results_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    chars_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic send_char(input logic [hpt_pkg::CharW-1:0] c, input logic fin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      chars_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    chars_ch.valid     <= 1'b1;
    chars_ch.char_in   <= c;
    chars_ch.last_char <= fin;
    @(posedge clk_i);
    while (!chars_ch.ready) @(posedge clk_i);
    chars_sent++;
    phase_chars++;
    if (fin) strings_sent++;
  endtask

  task automatic append_char(input logic [hpt_pkg::CharW-1:0] c);
    header_q.insert(header_q.size(), c);
  endtask

  function automatic logic [hpt_pkg::CharW-1:0] any_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 16'($urandom_range(97, 122));
    if (pick < 50) return hpt_pkg::ChSpace;
    if (pick < 56) return 16'($urandom_range(9, 13));
    if (pick < 62) return hpt_pkg::ChQuote;
    if (pick < 68) return hpt_pkg::ChBackslash;
    if (pick < 73) return hpt_pkg::ChEquals;
    if (pick < 78) return hpt_pkg::ChSemi;
    if (pick < 83) return cur_sep;
    if (pick < 86) return 16'hFFFF;
    if (pick < 88) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic push_blank();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 4) == 0) append_char(16'($urandom_range(9, 13)));
      else append_char(hpt_pkg::ChSpace);
    end
  endtask

  task automatic push_word(input int unsigned maxlen);
    int unsigned pick;
    repeat ($urandom_range(0, maxlen)) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) append_char(16'($urandom_range(97, 122)));
      else if (pick == 7) append_char(hpt_pkg::ChSpace);
      else append_char(any_char());
    end
  endtask

  // mostly lead; name=value; ... with random content, some pure noise
  task automatic make_header();
    int unsigned nparams;
    header_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) append_char(any_char());
    end else begin
      if (cur_lead) begin
        push_blank();
        push_word(6);
        if ($urandom_range(0, 5) != 0) append_char(hpt_pkg::ChSemi);
      end
      nparams = $urandom_range(0, 3);
      for (int p = 0; p < nparams; p++) begin
        push_blank();
        push_word(5);
        push_blank();
        if ($urandom_range(0, 9) != 0) append_char(hpt_pkg::ChEquals);
        push_blank();
        if ($urandom_range(0, 2) == 0) begin
          append_char(hpt_pkg::ChQuote);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
              0: append_char(cur_sep);
              1: begin
                append_char(hpt_pkg::ChBackslash);
                append_char(any_char());
              end
              2: append_char(hpt_pkg::ChSpace);
              default: append_char(16'($urandom_range(97, 122)));
            endcase
          end
          if ($urandom_range(0, 4) != 0) append_char(hpt_pkg::ChQuote);
        end else begin
          push_word(5);
          if ($urandom_range(0, 4) == 0) begin
            append_char(hpt_pkg::ChBackslash);
            append_char(any_char());
          end
        end
        // long space run around the saturation point
        if (p == 0 && strings_sent % 40 == 7) begin
          append_char(16'd120);
          repeat ($urandom_range(254, 262)) append_char(hpt_pkg::ChSpace);
          append_char(16'd121);
        end
        push_blank();
        if (p < nparams - 1 || $urandom_range(0, 1) == 0) append_char(cur_sep);
      end
    end
    if (header_q.size() == 0) append_char(any_char());
  endtask

  task automatic run_phase(input logic [hpt_pkg::CharW-1:0] sep, input logic esc,
                           input logic lead, input logic hold);
    wait_idle();
    write_reg(hpt_pkg::CfgSeparator, {16'h0000, sep});
    write_reg(hpt_pkg::CfgEscOff, {31'd0, esc});
    write_reg(hpt_pkg::CfgLeadMode, {31'd0, lead});
    cur_sep  = sep;
    cur_lead = lead;
    settings_run++;
    if (hold) hold_req = 1'b1;
    phase_chars = 0;
    while (phase_chars < PhaseChars) begin
      make_header();
      for (int i = 0; i < header_q.size(); i++) send_char(header_q[i], i == header_q.size() - 1);
    end
  endtask

  initial begin
    results_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        results_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        results_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        results_ch.ready <= 1'b1;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    string directed_s;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    chars_ch.valid     <= 1'b0;
    chars_ch.char_in   <= '0;
    chars_ch.last_char <= 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    cur_sep      = hpt_pkg::SeparatorRst;
    cur_lead     = 1'b1;
    chars_sent   = 0;
    strings_sent = 0;
    settings_run = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lead with held spaces, quoted separator, escapes, empty names, empty params
    directed_s = " a\t b ;n=\"x;\\\"\"\\;v ;=q;";
    for (int i = 0; i < directed_s.len(); i++)
      send_char(16'(directed_s[i]), i == directed_s.len() - 1);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0000, 1'b0);
    send_char(hpt_pkg::ChBackslash, 1'b1);

    run_phase(16'd44, 1'b1, 1'b0, 1'b0);
    run_phase(16'hFFFF, 1'b0, 1'b1, 1'b1);
    run_phase(16'd0, 1'b1, 1'b0, 1'b0);
    run_phase(hpt_pkg::ChSpace, 1'b0, 1'b1, 1'b0);
    run_phase(hpt_pkg::ChEquals, 1'b1, 1'b1, 1'b0);
    run_phase(hpt_pkg::ChQuote, 1'b0, 1'b0, 1'b0);
    run_phase(hpt_pkg::ChBackslash, 1'b0, 1'b1, 1'b0);
    idle_on = 1'b0;
    run_phase(hpt_pkg::SeparatorRst, 1'b0, 1'b1, 1'b0);
    wait_idle();

    $display("Sent %0d characters in %0d strings under %0d register settings; %0d results checked.",
             chars_sent, strings_sent, settings_run, checked);
    $display("Run included output hold-offs of %0d cycles and space runs past the count limit.",
             HoldCycles);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_if.sv
rtl/core/header_parameter_tokenizer.sv
bench/hpt_stream_checker.sv
bench/header_parameter_tokenizer_tb.sv
